[rtl/cnpr_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package cnpr_pkg;

	// Gate configuration of the node.
	localparam int NUM_GATES = 4;
	localparam logic [3:0] GATE_MASK = 4'(((1 << NUM_GATES) - 1) & 15);

	// Depth of the response queue between the front and back parts.
	localparam int RESP_DEPTH = 2;
	localparam int RESP_PTR_W = (RESP_DEPTH > 1) ? $clog2(RESP_DEPTH) : 1;
	localparam int RESP_CNT_W = $clog2(RESP_DEPTH + 1);

	// Configuration register indexes.
	localparam logic [2:0] REG_MASTER_ADDRESS  = 3'd0;
	localparam logic [2:0] REG_ACK_CODE        = 3'd1;
	localparam logic [2:0] REG_NACK_CODE       = 3'd2;
	localparam logic [2:0] REG_CABINET_SHAPE   = 3'd3;
	localparam logic [2:0] REG_BOOT_PRODUCT_ID = 3'd4;

	// Command codes in the upper nibble of the command byte.
	localparam logic [3:0] CMD_ACTIVATE    = 4'd0;
	localparam logic [3:0] CMD_DEACTIVATE  = 4'd1;
	localparam logic [3:0] CMD_IDENTIFY    = 4'd2;
	localparam logic [3:0] CMD_SET_LED     = 4'd6;
	localparam logic [3:0] CMD_SET_PRODUCT = 4'd7;

	// Fixed response codes of the identify command.
	localparam logic [3:0] CODE_ID_ASSIGNED = 4'd3;
	localparam logic [3:0] CODE_ID_REFUSED  = 4'd4;

	// One response packet as queued between the front and back parts.
	typedef struct packed {
		logic [7:0]       master;
		logic [3:0]       code;
		logic             four;
		logic [3:0][7:0]  data;
		logic [3:0]       gates;
	} resp_t;

endpackage
`default_nettype wire

[rtl/cnpr_front.sv]
`timescale 1ns / 1ps
`default_nettype none
module cnpr_front
	import cnpr_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       accept,
	input  wire logic [7:0] rx_byte,
	input  wire logic [3:0] gate_sense,
	input  wire logic       store_ok,
	input  wire logic       cfg_write,
	input  wire logic [2:0] cfg_index,
	input  wire logic [7:0] cfg_data,
	output logic            resp_push,
	output resp_t           resp
);

	logic [4:0] byte_count_q;
	logic [7:0] target_q;
	logic [7:0] command_q;
	logic [7:0] first_data_q;
	logic [7:0] node_id_q;
	logic [7:0] product_q;
	logic [3:0] driven_q;
	logic [7:0] master_q;
	logic [3:0] ack_code_q;
	logic [3:0] nack_code_q;
	logic [7:0] shape_q;

	logic [4:0] count_next;
	logic [7:0] cmd_byte;
	logic [7:0] fd;
	logic [3:0] cmd;
	logic       done;
	logic       match;
	logic [3:0] sensed;
	logic [1:0] low_gate;
	logic       resp_valid;
	logic [3:0] driven_next;
	logic [7:0] node_id_next;
	logic [7:0] product_next;

	// Framing view of the byte that arrives now.
	assign count_next = byte_count_q + 5'd1;
	assign cmd_byte   = (byte_count_q == 5'd1) ? rx_byte : command_q;
	assign fd         = (byte_count_q == 5'd2) ? rx_byte : first_data_q;
	assign cmd        = cmd_byte[7:4];
	assign done       = (count_next >= 5'd2) && (count_next == 5'd2 + {1'b0, cmd_byte[3:0]});
	assign match      = (target_q == node_id_q) || (target_q == 8'd0);
	assign sensed     = gate_sense & GATE_MASK;

	// Lowest sensed gate, the top gate when none below it is sensed.
	always_comb begin
		if (sensed[0]) begin
			low_gate = 2'd0;
		end else if (sensed[1]) begin
			low_gate = 2'd1;
		end else if (sensed[2]) begin
			low_gate = 2'd2;
		end else begin
			low_gate = 2'd3;
		end
	end

	// Classify the completed packet and build its response.
	always_comb begin
		resp_valid   = 1'b0;
		driven_next  = driven_q;
		node_id_next = node_id_q;
		product_next = product_q;
		resp.master  = master_q;
		resp.code    = ack_code_q;
		resp.four    = 1'b0;
		resp.data    = '0;
		resp.data[0] = node_id_q;
		resp.data[1] = {4'd0, cmd};
		if (match) begin
			case (cmd)
				CMD_ACTIVATE, CMD_DEACTIVATE: begin
					if (fd < 8'(NUM_GATES)) begin
						resp_valid = 1'b1;
						if (fd[7:2] == 6'd0) begin
							if (cmd == CMD_ACTIVATE) begin
								driven_next = (driven_q | (4'd1 << fd[1:0])) & GATE_MASK;
							end else begin
								driven_next = (driven_q & ~(4'd1 << fd[1:0])) & GATE_MASK;
							end
						end
					end
				end
				CMD_IDENTIFY: begin
					if (sensed != 4'd0 && driven_q == 4'd0) begin
						resp_valid   = 1'b1;
						resp.data[1] = {6'd0, low_gate};
						if (node_id_q == 8'd0) begin
							node_id_next = fd;
							resp.code    = CODE_ID_ASSIGNED;
							resp.four    = 1'b1;
							resp.data[0] = fd;
							resp.data[2] = shape_q;
							resp.data[3] = product_q;
						end else begin
							resp.code = CODE_ID_REFUSED;
						end
					end
				end
				CMD_SET_LED: begin
					resp_valid = 1'b1;
				end
				CMD_SET_PRODUCT: begin
					resp_valid   = 1'b1;
					product_next = fd;
					resp.code    = store_ok ? ack_code_q : nack_code_q;
				end
				default: begin
					resp_valid = 1'b0;
				end
			endcase
		end
		resp.gates = driven_next;
	end

	assign resp_push = accept && done && resp_valid;

	// Framing, node state and configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q <= '0;
			target_q     <= '0;
			command_q    <= '0;
			first_data_q <= '0;
			node_id_q    <= '0;
			product_q    <= '0;
			driven_q     <= '0;
			master_q     <= '0;
			ack_code_q   <= 4'd8;
			nack_code_q  <= 4'd9;
			shape_q      <= '0;
		end else begin
			if (accept) begin
				if (done) begin
					byte_count_q <= '0;
					target_q     <= '0;
					command_q    <= '0;
					first_data_q <= '0;
					driven_q     <= driven_next;
					node_id_q    <= node_id_next;
					product_q    <= product_next;
				end else begin
					byte_count_q <= count_next;
					if (byte_count_q == 5'd0) begin
						target_q <= rx_byte;
					end
					if (byte_count_q == 5'd1) begin
						command_q <= rx_byte;
					end
					if (byte_count_q == 5'd2) begin
						first_data_q <= rx_byte;
					end
				end
			end
			if (cfg_write) begin
				case (cfg_index)
					REG_MASTER_ADDRESS:  master_q    <= cfg_data;
					REG_ACK_CODE:        ack_code_q  <= cfg_data[3:0];
					REG_NACK_CODE:       nack_code_q <= cfg_data[3:0];
					REG_CABINET_SHAPE:   shape_q     <= cfg_data;
					REG_BOOT_PRODUCT_ID: product_q   <= cfg_data;
					default: begin
					end
				endcase
			end
		end
	end

endmodule
`default_nettype wire

[rtl/cnpr_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
module cnpr_queue
	import cnpr_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	input  wire resp_t push_data,
	input  wire logic  pop,
	output resp_t      head,
	output logic       q_empty,
	output logic       q_full
);

	resp_t                  slots_q [RESP_DEPTH];
	logic [RESP_PTR_W-1:0]  wr_ptr_q;
	logic [RESP_PTR_W-1:0]  rd_ptr_q;
	logic [RESP_CNT_W-1:0]  count_q;

	assign head    = slots_q[rd_ptr_q];
	assign q_empty = (count_q == '0);
	assign q_full  = (count_q == RESP_CNT_W'(RESP_DEPTH));

	// Response storage.
	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == RESP_PTR_W'(RESP_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == RESP_PTR_W'(RESP_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

[rtl/cnpr_back.sv]
`timescale 1ns / 1ps
`default_nettype none
module cnpr_back
	import cnpr_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire resp_t head,
	input  wire logic  q_empty,
	output logic       q_pop,
	input  wire logic  pop,
	output logic       empty,
	output logic [7:0] tx_byte,
	output logic       tx_last,
	output logic [3:0] gate_drive
);

	logic [2:0] idx_q;
	logic       out_valid_q;
	logic [7:0] tx_byte_q;
	logic       tx_last_q;
	logic [3:0] gate_drive_q;

	logic       load;
	logic       last;
	logic [7:0] byte_sel;

	assign load = !q_empty && (!out_valid_q || pop);
	assign last = (idx_q == (head.four ? 3'd5 : 3'd3));

	// Byte of the head response at the current position.
	always_comb begin
		case (idx_q)
			3'd0:    byte_sel = head.master;
			3'd1:    byte_sel = {head.code, head.four ? 4'd4 : 4'd2};
			3'd2:    byte_sel = head.data[0];
			3'd3:    byte_sel = head.data[1];
			3'd4:    byte_sel = head.data[2];
			3'd5:    byte_sel = head.data[3];
			default: byte_sel = 8'd0;
		endcase
	end

	assign q_pop      = load && last;
	assign empty      = !out_valid_q;
	assign tx_byte    = tx_byte_q;
	assign tx_last    = tx_last_q;
	assign gate_drive = gate_drive_q;

	// Output register and byte position.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q        <= '0;
			out_valid_q  <= 1'b0;
			tx_byte_q    <= '0;
			tx_last_q    <= 1'b0;
			gate_drive_q <= '0;
		end else begin
			if (load) begin
				out_valid_q  <= 1'b1;
				tx_byte_q    <= byte_sel;
				tx_last_q    <= last;
				gate_drive_q <= head.gates;
				idx_q        <= last ? 3'd0 : idx_q + 3'd1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

[rtl/cabinet_node_packet_responder.sv]
// Channel   Handshake            Payload
// input     push / full          rx_byte, gate_sense, store_ok
// result    empty / pop          tx_byte, tx_last, gate_drive
// config    cfg_write            cfg_index, cfg_data
//
// One received byte is taken per cycle while full is low; the front part frames
// and executes the packet in the cycle its last byte arrives.
// Each response of four or six bytes goes to a two-entry response queue and
// leaves at one byte per cycle through the output register while pop is high.
// full is high while both queue entries hold responses; pop low stalls output.
// Reset is asynchronous; no clearing pass is needed afterward.
`timescale 1ns / 1ps
`default_nettype none
module cabinet_node_packet_responder
	import cnpr_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push,
	output logic            full,
	input  wire logic [7:0] rx_byte,
	input  wire logic [3:0] gate_sense,
	input  wire logic       store_ok,
	output logic            empty,
	input  wire logic       pop,
	output logic [7:0]      tx_byte,
	output logic            tx_last,
	output logic [3:0]      gate_drive,
	input  wire logic       cfg_write,
	input  wire logic [2:0] cfg_index,
	input  wire logic [7:0] cfg_data
);

	logic  accept;
	logic  resp_push;
	resp_t resp;
	resp_t head;
	logic  q_empty;
	logic  q_full;
	logic  q_pop;

	assign full   = q_full;
	assign accept = push && !q_full;

	// Packet framing and command execution.
	cnpr_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.rx_byte    (rx_byte),
		.gate_sense (gate_sense),
		.store_ok   (store_ok),
		.cfg_write  (cfg_write),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.resp_push  (resp_push),
		.resp       (resp)
	);

	// Response queue.
	cnpr_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (resp_push),
		.push_data (resp),
		.pop       (q_pop),
		.head      (head),
		.q_empty   (q_empty),
		.q_full    (q_full)
	);

	// Response serializer.
	cnpr_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.q_empty    (q_empty),
		.q_pop      (q_pop),
		.pop        (pop),
		.empty      (empty),
		.tx_byte    (tx_byte),
		.tx_last    (tx_last),
		.gate_drive (gate_drive)
	);

endmodule
`default_nettype wire

[rtl/cnpr_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
module cnpr_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       empty,
	input wire logic       pop,
	input wire logic [7:0] tx_byte,
	input wire logic       tx_last,
	input wire logic [3:0] gate_drive
);

	// A waiting result byte holds until it is taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(tx_byte) && $stable(tx_last)))
		else $error("result byte changed while stalled");

	// Bytes of one response follow without a gap and report the same gates.
	assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !empty && !tx_last) |=> (!empty && $stable(gate_drive)))
		else $error("response packet broken or gate state changed inside it");

	// Nothing is offered right after reset.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> empty)
		else $error("result offered right after reset");

endmodule

bind cabinet_node_packet_responder cnpr_checker u_cnpr_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.empty      (empty),
	.pop        (pop),
	.tx_byte    (tx_byte),
	.tx_last    (tx_last),
	.gate_drive (gate_drive)
);
`default_nettype wire

[sim/tb_cabinet_node_packet_responder.sv]
`timescale 1ns / 1ps
module tb_cabinet_node_packet_responder;
	import cnpr_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int SETTLE_CYCLES = 20;
	localparam int PHASE_BYTES = 72;
	localparam int LONG_HOLD = 250;
	localparam logic [7:0] BROADCAST = 8'h00;
	localparam logic [7:0] ASSIGNED_ID = 8'hA5;
	localparam logic [7:0] OTHER_NODE = 8'h3C;
	localparam logic [3:0] CMD_RESERVED_TOP = 4'd15;

	// One response byte as it leaves the block.
	typedef struct packed {
		logic [7:0] tx;
		logic       last;
		logic [3:0] gates;
	} tx_beat_t;

	typedef enum int {POP_STEADY, POP_COIN, POP_THIRD, POP_MOSTLY} pop_mode_t;

	// Tracks the node state and the response bytes still owed by the block.
	class responder_scoreboard;
		logic [7:0] master_addr;
		logic [3:0] ack;
		logic [3:0] nack;
		logic [7:0] shape;
		logic [7:0] boot_pid;
		logic [4:0] frame_cnt;
		logic [7:0] target;
		logic [7:0] command;
		logic [7:0] first;
		logic [7:0] node_id;
		logic [7:0] product;
		logic [3:0] driven;
		tx_beat_t   owed[$];
		int         failures;

		function new();
			master_addr = 8'h00;
			ack = 4'd8;
			nack = 4'd9;
			shape = 8'h00;
			boot_pid = 8'h00;
			frame_cnt = '0;
			target = '0;
			command = '0;
			first = '0;
			node_id = '0;
			product = 8'h00;
			driven = '0;
			failures = 0;
		endfunction

		function void write_reg(logic [2:0] idx, logic [7:0] val);
			case (idx)
				REG_MASTER_ADDRESS:  master_addr = val;
				REG_ACK_CODE:        ack = val[3:0];
				REG_NACK_CODE:       nack = val[3:0];
				REG_CABINET_SHAPE:   shape = val;
				REG_BOOT_PRODUCT_ID: begin
					boot_pid = val;
					product = val;
				end
				default: ;
			endcase
		endfunction

		// Queues one response packet; the gate field carries the state after execution.
		function void queue_response(logic [3:0] code, logic [3:0] len,
				logic [7:0] d0, logic [7:0] d1, logic [7:0] d2, logic [7:0] d3);
			logic [7:0] bytes [6];
			int total;
			int k;
			bytes[0] = master_addr;
			bytes[1] = {code, len};
			bytes[2] = d0;
			bytes[3] = d1;
			bytes[4] = d2;
			bytes[5] = d3;
			total = 2 + int'(len);
			for (k = 0; k < total; k++) begin
				owed.push_back('{tx: bytes[k], last: (k == total - 1), gates: driven});
			end
		endfunction

		// Frames one accepted byte and executes the packet when it is complete.
		function void note_request(logic [7:0] rx, logic [3:0] sense, logic ok);
			logic [3:0] cmd;
			logic [3:0] sensed;
			logic [7:0] gate;
			int k;
			case (frame_cnt)
				5'd0: target = rx;
				5'd1: command = rx;
				5'd2: first = rx;
				default: ;
			endcase
			frame_cnt = frame_cnt + 5'd1;
			if (frame_cnt >= 5'd2 && int'(frame_cnt) == 2 + int'(command[3:0])) begin
				cmd = command[7:4];
				if (target == node_id || target == BROADCAST) begin
					case (cmd)
						CMD_ACTIVATE, CMD_DEACTIVATE: begin
							if (int'(first) < NUM_GATES) begin
								if (first < 8'd4)
									driven[first[1:0]] = (cmd == CMD_ACTIVATE);
								driven = driven & GATE_MASK;
								queue_response(ack, 4'd2, node_id, {4'd0, cmd}, 8'h00, 8'h00);
							end
						end
						CMD_IDENTIFY: begin
							sensed = sense & GATE_MASK;
							if (sensed != '0 && driven == '0) begin
								gate = 8'd3;
								for (k = 2; k >= 0; k--) begin
									if (sensed[k])
										gate = 8'(k);
								end
								if (node_id == '0) begin
									node_id = first;
									queue_response(CODE_ID_ASSIGNED, 4'd4, node_id, gate, shape,
										product);
								end else begin
									queue_response(CODE_ID_REFUSED, 4'd2, node_id, gate, 8'h00,
										8'h00);
								end
							end
						end
						CMD_SET_LED: begin
							queue_response(ack, 4'd2, node_id, {4'd0, CMD_SET_LED}, 8'h00, 8'h00);
						end
						CMD_SET_PRODUCT: begin
							product = first;
							queue_response(ok ? ack : nack, 4'd2, node_id,
								{4'd0, CMD_SET_PRODUCT}, 8'h00, 8'h00);
						end
						default: ;
					endcase
				end
				frame_cnt = '0;
				target = '0;
				command = '0;
				first = '0;
			end
		endfunction

		// Compares one popped byte with the oldest owed byte.
		function void check_result(logic [7:0] tx, logic last, logic [3:0] gates);
			tx_beat_t got;
			tx_beat_t want;
			got = '{tx: tx, last: last, gates: gates};
			if (owed.size() == 0) begin
				failures++;
				if (failures <= 10)
					$display("unexpected response byte %02h last %0d gates %h", tx, last, gates);
			end else begin
				want = owed.pop_front();
				if (got != want) begin
					failures++;
					if (failures <= 10)
						$display("mismatch: expected byte %02h last %0d gates %h, got byte %02h last %0d gates %h",
							want.tx, want.last, want.gates, got.tx, got.last, got.gates);
				end
			end
		endfunction

		function int pending();
			return owed.size();
		endfunction
	endclass

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       push = 1'b0;
	logic       full;
	logic [7:0] rx_byte = '0;
	logic [3:0] gate_sense = '0;
	logic       store_ok = 1'b0;
	logic       empty;
	logic       pop = 1'b0;
	logic [7:0] tx_byte;
	logic       tx_last;
	logic [3:0] gate_drive;
	logic       cfg_write = 1'b0;
	logic [2:0] cfg_index = '0;
	logic [7:0] cfg_data = '0;

	responder_scoreboard sb = new();
	int burst_left = 0;
	int hold_request = 0;
	int cycle_count = 0;

	cabinet_node_packet_responder dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.rx_byte    (rx_byte),
		.gate_sense (gate_sense),
		.store_ok   (store_ok),
		.empty      (empty),
		.pop        (pop),
		.tx_byte    (tx_byte),
		.tx_last    (tx_last),
		.gate_drive (gate_drive),
		.cfg_write  (cfg_write),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// Run limit.
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb_cabinet_node_packet_responder: FAIL");
		$finish;
	end

	// Receiver: stalls on changing patterns, or holds off for a requested stretch.
	initial begin
		pop_mode_t mode;
		int seg_left;
		int hold_left;
		int third;
		mode = POP_STEADY;
		seg_left = 0;
		hold_left = 0;
		third = 0;
		forever begin
			@(negedge clk);
			if (hold_request > 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else begin
				if (seg_left == 0) begin
					mode = pop_mode_t'($urandom_range(0, 3));
					seg_left = $urandom_range(20, 80);
				end
				seg_left--;
				third = (third + 1) % 3;
				case (mode)
					POP_STEADY: pop <= 1'b1;
					POP_COIN:   pop <= 1'($urandom_range(0, 1));
					POP_THIRD:  pop <= (third == 0);
					default:    pop <= ($urandom_range(0, 99) < 85);
				endcase
			end
		end
	end

	// Each popped response byte is checked at the edge that takes it.
	always @(posedge clk) begin
		if (pop && !empty)
			sb.check_result(tx_byte, tx_last, gate_drive);
	end

	// Offers one byte until it is taken, then maybe leaves a gap after the burst.
	task automatic send_byte(input logic [7:0] b, input logic [3:0] sense, input logic ok);
		@(negedge clk);
		push <= 1'b1;
		rx_byte <= b;
		gate_sense <= sense;
		store_ok <= ok;
		@(posedge clk);
		while (full)
			@(posedge clk);
		sb.note_request(b, sense, ok);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 60) :
				$urandom_range(1, 10);
			repeat ($urandom_range(0, 5)) begin
				@(negedge clk);
				push <= 1'b0;
			end
		end
	endtask

	task automatic send_frame(input logic [7:0] tgt, input logic [7:0] cmd_len,
			input logic [7:0] data, input int count, input logic [3:0] sense,
			input logic ok);
		send_byte(tgt, sense, ok);
		send_byte(cmd_len, sense, ok);
		if (count > 2)
			send_byte(data, sense, ok);
	endtask

	function automatic logic [3:0] random_sense();
		return ($urandom_range(0, 4) == 0) ? 4'd0 : 4'($urandom);
	endfunction

	// A well formed packet with random content, biased toward commands that act.
	task automatic send_random_packet(inout int counted);
		logic [7:0] tgt;
		logic [7:0] b;
		logic [3:0] cmd;
		logic [3:0] len;
		int pick;
		int k;
		pick = $urandom_range(0, 99);
		tgt = (pick < 55) ? BROADCAST : (pick < 90) ? sb.node_id : 8'($urandom);
		pick = $urandom_range(0, 99);
		if (pick < 20)
			cmd = CMD_ACTIVATE;
		else if (pick < 45)
			cmd = CMD_DEACTIVATE;
		else if (pick < 60)
			cmd = CMD_IDENTIFY;
		else if (pick < 72)
			cmd = CMD_SET_LED;
		else if (pick < 86)
			cmd = CMD_SET_PRODUCT;
		else
			cmd = 4'($urandom);
		pick = $urandom_range(0, 99);
		len = (pick < 6) ? 4'($urandom_range(4, 15)) : (pick < 15) ? 4'd0 :
			(pick < 75) ? 4'd1 : 4'($urandom_range(2, 3));
		send_byte(tgt, random_sense(), 1'($urandom));
		send_byte({cmd, len}, random_sense(), 1'($urandom));
		for (k = 0; k < int'(len); k++) begin
			if (k == 0 && (cmd == CMD_ACTIVATE || cmd == CMD_DEACTIVATE) &&
					$urandom_range(0, 9) < 8)
				b = 8'($urandom_range(0, NUM_GATES - 1));
			else
				b = 8'($urandom);
			send_byte(b, random_sense(), 1'($urandom));
		end
		counted += 2 + int'(len);
	endtask

	// Lets the block finish every owed response, then a little longer.
	task automatic drain();
		@(negedge clk);
		push <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		sb.write_reg(idx, val);
	endtask

	task automatic apply_settings(input logic [7:0] master, input logic [7:0] ack_val,
			input logic [7:0] nack_val, input logic [7:0] shape, input logic [7:0] boot_pid);
		write_reg(REG_MASTER_ADDRESS, master);
		write_reg(REG_ACK_CODE, ack_val);
		write_reg(REG_NACK_CODE, nack_val);
		write_reg(REG_CABINET_SHAPE, shape);
		write_reg(REG_BOOT_PRODUCT_ID, boot_pid);
		@(negedge clk);
		cfg_write <= 1'b0;
	endtask

	initial begin
		int counted;
		int phase;
		int k;
		repeat (4)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed packets on reset settings; the node id is still unassigned.
		// Identify without data keeps the id at zero and still answers.
		send_frame(BROADCAST, {CMD_IDENTIFY, 4'd0}, 8'h00, 2, 4'b1000, 1'b1);
		// Product id change with a failing store.
		send_frame(BROADCAST, {CMD_SET_PRODUCT, 4'd1}, 8'hFF, 3, 4'b0000, 1'b0);
		send_frame(BROADCAST, {CMD_ACTIVATE, 4'd1}, 8'h03, 3, 4'b0000, 1'b1);
		// Identify while a gate is driven gives no response.
		send_frame(BROADCAST, {CMD_IDENTIFY, 4'd0}, 8'h00, 2, 4'b0001, 1'b1);
		// Gate index out of range is ignored.
		send_frame(BROADCAST, {CMD_ACTIVATE, 4'd1}, 8'h04, 3, 4'b0000, 1'b1);
		send_frame(BROADCAST, {CMD_DEACTIVATE, 4'd1}, 8'h03, 3, 4'b0000, 1'b1);
		// Identify with no sensed gate gives no response.
		send_frame(BROADCAST, {CMD_IDENTIFY, 4'd1}, 8'h55, 3, 4'b0000, 1'b1);
		send_frame(BROADCAST, {CMD_IDENTIFY, 4'd1}, ASSIGNED_ID, 3, 4'b1111, 1'b1);
		send_frame(ASSIGNED_ID, {CMD_SET_LED, 4'd0}, 8'h00, 2, 4'b0000, 1'b1);
		// A packet for another node and an unused command are both ignored.
		send_frame(OTHER_NODE, {CMD_SET_LED, 4'd0}, 8'h00, 2, 4'b0000, 1'b1);
		send_frame(ASSIGNED_ID, {CMD_RESERVED_TOP, 4'd0}, 8'h00, 2, 4'b0000, 1'b1);
		// Identify on a node that already has an id is refused.
		send_frame(ASSIGNED_ID, {CMD_IDENTIFY, 4'd0}, 8'h00, 2, 4'b0100, 1'b1);
		drain();

		// Random phases, each on its own settings.
		for (phase = 1; phase <= 4; phase++) begin
			case (phase)
				1: apply_settings(8'h00, 8'hF0, 8'hF0, 8'h00, 8'h00);
				2: begin
					apply_settings(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
					hold_request = LONG_HOLD;
				end
				default: apply_settings(8'($urandom), 8'($urandom), 8'($urandom),
					8'($urandom), 8'($urandom));
			endcase
			counted = 0;
			while (counted < PHASE_BYTES) begin
				if ($urandom_range(0, 99) < 8) begin
					// Loose bytes break the framing; more follow until a packet closes.
					repeat ($urandom_range(1, 5)) begin
						send_byte(8'($urandom), random_sense(), 1'($urandom));
						counted++;
					end
					k = 0;
					while (sb.frame_cnt != '0 && k < 40) begin
						send_byte(8'($urandom), random_sense(), 1'($urandom));
						counted++;
						k++;
					end
				end else begin
					send_random_packet(counted);
				end
			end
			drain();
		end

		if (sb.pending() != 0)
			sb.failures++;
		if (sb.failures == 0)
			$display("tb_cabinet_node_packet_responder: PASS");
		else
			$display("tb_cabinet_node_packet_responder: FAIL");
		$finish;
	end

endmodule
